// ----- rtl/sfe_pkg.sv -----
package sfe_pkg;

  // default width of the position counter
  localparam int unsigned POSITION_BITS_DEF = 20;

  // configuration port
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_LEN_W   = 21;
  localparam int unsigned CFG_DATA_W  = CFG_LEN_W;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_DIR_IN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES  = 2'd2;

  // sample and gain arithmetic
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned NARROW_W   = 8;
  localparam int unsigned GAIN_SHIFT = 10;            // gain of one is 1024
  localparam int unsigned QUOT_W     = GAIN_SHIFT + 1; // quotient never exceeds 1024
  localparam int unsigned CNT_W      = $clog2(QUOT_W);

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_OUT
  } bk_state_t;

endpackage

// ----- rtl/sfe_front.sv -----
module sfe_front #(
  parameter int unsigned POSITION_BITS = sfe_pkg::POSITION_BITS_DEF,
  localparam int unsigned LEN_W  = POSITION_BITS + 1,
  localparam int unsigned DIVD_W = LEN_W + sfe_pkg::GAIN_SHIFT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_push,
  input  logic [sfe_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [DIVD_W-1:0]                 job_dividend,
  output logic [LEN_W-1:0]                  job_len,
  output logic [sfe_pkg::SAMPLE_W-1:0]      job_mag,
  output logic                              job_neg,
  output logic                              job_wide,
  output logic                              job_done
);

  localparam int unsigned MAX_LEN = 1 << POSITION_BITS;
  localparam int unsigned EXT_W   = sfe_pkg::CFG_LEN_W + 1;

  logic [sfe_pkg::CFG_LEN_W-1:0] region_length_r;
  logic                          fade_in_r;
  logic                          wide_r;
  logic [POSITION_BITS-1:0]      pos_r;
  logic [POSITION_BITS-1:0]      pos_nxt;

  logic [LEN_W-1:0]              len_c;
  logic [LEN_W-1:0]              last_c;
  logic [POSITION_BITS-1:0]      idx_c;
  logic                          done_c;
  logic [LEN_W-1:0]              factor_c;
  logic [sfe_pkg::SAMPLE_W-1:0]  mag16_c;
  logic [sfe_pkg::NARROW_W-1:0]  mag8_c;
  logic [LEN_W+sfe_pkg::NARROW_W-1:0] prod8_c;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_length_r <= sfe_pkg::CFG_LEN_W'(1);
      fade_in_r       <= 1'b1;
      wide_r          <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        sfe_pkg::REG_REGION_LENGTH: region_length_r <= cfg_wdata[sfe_pkg::CFG_LEN_W-1:0];
        sfe_pkg::REG_FADE_DIR_IN:   fade_in_r       <= cfg_wdata[0];
        sfe_pkg::REG_WIDE_SAMPLES:  wide_r          <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective length and clamped position
  always_comb begin
    if (region_length_r == '0) begin
      len_c = LEN_W'(1);
    end else if ({1'b0, region_length_r} > EXT_W'(MAX_LEN)) begin
      len_c = LEN_W'(MAX_LEN);
    end else begin
      len_c = LEN_W'(region_length_r);
    end
    last_c = len_c - LEN_W'(1);
    if ({1'b0, pos_r} > last_c) begin
      idx_c = last_c[POSITION_BITS-1:0];
    end else begin
      idx_c = pos_r;
    end
    done_c   = ({1'b0, idx_c} == last_c);
    factor_c = fade_in_r ? {1'b0, idx_c} : (len_c - {1'b0, idx_c});
  end

  // sign and magnitude, dividend for the back end
  always_comb begin
    mag16_c = in_sample[sfe_pkg::SAMPLE_W-1] ? (~in_sample + 16'd1) : in_sample;
    mag8_c  = in_sample[sfe_pkg::NARROW_W-1] ?
              (~in_sample[sfe_pkg::NARROW_W-1:0] + 8'd1) : in_sample[sfe_pkg::NARROW_W-1:0];
    prod8_c = mag8_c * factor_c;
    if (wide_r) begin
      job_dividend = DIVD_W'(factor_c) << sfe_pkg::GAIN_SHIFT;
      job_mag      = mag16_c;
      job_neg      = in_sample[sfe_pkg::SAMPLE_W-1];
    end else begin
      job_dividend = DIVD_W'(prod8_c);
      job_mag      = sfe_pkg::SAMPLE_W'(mag8_c);
      job_neg      = in_sample[sfe_pkg::NARROW_W-1];
    end
    job_len  = len_c;
    job_wide = wide_r;
    job_done = done_c;
  end

  assign q_push  = in_push && !q_full;
  assign pos_nxt = done_c ? '0 : idx_c + POSITION_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ----- rtl/sfe_queue.sv -----
module sfe_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = sfe_pkg::QUEUE_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/sfe_back.sv -----
module sfe_back #(
  parameter int unsigned POSITION_BITS = sfe_pkg::POSITION_BITS_DEF,
  localparam int unsigned LEN_W  = POSITION_BITS + 1,
  localparam int unsigned DIVD_W = LEN_W + sfe_pkg::GAIN_SHIFT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [DIVD_W-1:0]             job_dividend,
  input  logic [LEN_W-1:0]              job_len,
  input  logic [sfe_pkg::SAMPLE_W-1:0]  job_mag,
  input  logic                          job_neg,
  input  logic                          job_wide,
  input  logic                          job_done,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic [sfe_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                          out_done
);

  localparam int unsigned QW     = sfe_pkg::QUOT_W;
  localparam int unsigned PROD_W = sfe_pkg::SAMPLE_W + QW;

  sfe_pkg::bk_state_t state_r;
  sfe_pkg::bk_state_t state_nxt;

  logic [LEN_W-1:0]              len_r;
  logic [LEN_W-1:0]              rem_r;
  logic [QW-1:0]                 low_r;
  logic [sfe_pkg::CNT_W-1:0]     cnt_r;
  logic [sfe_pkg::SAMPLE_W-1:0]  mag_r;
  logic                          neg_r;
  logic                          wide_r;
  logic                          done_r;
  logic [sfe_pkg::SAMPLE_W-1:0]  res_r;

  logic                          out_valid_r;
  logic [sfe_pkg::SAMPLE_W-1:0]  out_sample_r;
  logic                          out_done_r;

  logic                          slot_free;
  logic                          div_step;
  logic                          do_mul;
  logic                          load_out;
  logic                          last_step;

  logic [LEN_W:0]                trial;
  logic [LEN_W:0]                diff;
  logic                          ge;
  logic [PROD_W-1:0]             prod;
  logic [sfe_pkg::SAMPLE_W-1:0]  val;

  assign slot_free = !out_valid_r || out_pop;
  assign last_step = (cnt_r == sfe_pkg::CNT_W'(QW - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfe_pkg::BK_IDLE: if (!q_empty)  state_nxt = sfe_pkg::BK_DIV;
      sfe_pkg::BK_DIV:  if (last_step) state_nxt = sfe_pkg::BK_MUL;
      sfe_pkg::BK_MUL:                 state_nxt = sfe_pkg::BK_OUT;
      sfe_pkg::BK_OUT:  if (slot_free) state_nxt = sfe_pkg::BK_IDLE;
      default:                         state_nxt = sfe_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = 1'b0;
    div_step = 1'b0;
    do_mul   = 1'b0;
    load_out = 1'b0;
    case (state_r)
      sfe_pkg::BK_IDLE: q_pop    = !q_empty;
      sfe_pkg::BK_DIV:  div_step = 1'b1;
      sfe_pkg::BK_MUL:  do_mul   = 1'b1;
      sfe_pkg::BK_OUT:  load_out = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfe_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // restoring division step, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, low_r[QW-1]};
    diff  = trial - {1'b0, len_r};
    ge    = (trial >= {1'b0, len_r});
  end

  // gain times magnitude in wide mode (narrow mode takes the quotient as is), then sign
  always_comb begin
    prod = mag_r * low_r;
    val  = wide_r ? prod[sfe_pkg::GAIN_SHIFT+sfe_pkg::SAMPLE_W-1:sfe_pkg::GAIN_SHIFT]
                  : sfe_pkg::SAMPLE_W'(low_r);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      // quotient fits in QW bits, so the upper part is already below len
      rem_r  <= LEN_W'(job_dividend >> QW);
      low_r  <= job_dividend[QW-1:0];
      cnt_r  <= '0;
      len_r  <= job_len;
      mag_r  <= job_mag;
      neg_r  <= job_neg;
      wide_r <= job_wide;
      done_r <= job_done;
    end else if (div_step) begin
      rem_r <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      low_r <= {low_r[QW-2:0], ge};
      cnt_r <= cnt_r + sfe_pkg::CNT_W'(1);
    end
    if (do_mul) begin
      res_r <= neg_r ? (~val + 16'd1) : val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= res_r;
      out_done_r   <= done_r;
    end
  end

  assign out_empty  = !out_valid_r;
  assign out_sample = out_sample_r;
  assign out_done   = out_done_r;

endmodule

// ----- rtl/sample_fade_envelope.sv -----
// sample_fade_envelope: linear fade-in / fade-out over a region of samples
//
// input channel: queue-style, in_push with in_sample_in; a beat is taken when
//   in_push is high and in_full is low. each beat gives exactly one result.
// result channel: queue-style, out_sample_out and out_region_done are valid
//   while out_empty is low; a beat leaves when out_pop is high.
// config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//   region_length (0), fade_direction_in (1), wide_samples (2); other indexes
//   are ignored. write only while no sample is in flight.
// timing: the front end clamps the position, builds the dividend and queues
//   the job at the input beat. the back end handles one sample at a time:
//   it takes the job, runs 11 restoring-divider steps (one quotient bit each),
//   does the gain multiply and sign, then loads the result register, waiting
//   there while the result register is still full; it takes a new job only
//   after that load.
// stalls: a two-entry queue, the job held in the back end and the result
//   register let the front keep accepting while the receiver holds off; in_full
//   rises once the queue holds two jobs, so four samples are taken before the
//   input stalls.
// reset: synchronous, active low; position goes to 0, length to 1, fade-in
//   and 16-bit mode selected, queue and result register emptied.
module sample_fade_envelope #(
  parameter int unsigned POSITION_BITS = sfe_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // sample input
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [sfe_pkg::SAMPLE_W-1:0] in_sample_in,
  // faded output
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [sfe_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                              out_region_done
);

  localparam int unsigned LEN_W  = POSITION_BITS + 1;
  localparam int unsigned DIVD_W = LEN_W + sfe_pkg::GAIN_SHIFT;
  localparam int unsigned JOB_W  = DIVD_W + LEN_W + sfe_pkg::SAMPLE_W + 3;

  // front to queue
  logic                          q_push;
  logic                          q_full;
  logic [DIVD_W-1:0]             f_dividend;
  logic [LEN_W-1:0]              f_len;
  logic [sfe_pkg::SAMPLE_W-1:0]  f_mag;
  logic                          f_neg;
  logic                          f_wide;
  logic                          f_done;
  logic [JOB_W-1:0]              q_wdata;

  // queue to back
  logic                          q_pop;
  logic                          q_empty;
  logic [JOB_W-1:0]              q_rdata;
  logic [DIVD_W-1:0]             b_dividend;
  logic [LEN_W-1:0]              b_len;
  logic [sfe_pkg::SAMPLE_W-1:0]  b_mag;
  logic                          b_neg;
  logic                          b_wide;
  logic                          b_done;
  logic [sfe_pkg::SAMPLE_W-1:0]  b_sample;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  // front: config registers, position counter, job setup
  sfe_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_push      (in_push),
    .in_sample    (in_sample_in),
    .q_full       (q_full),
    .q_push       (q_push),
    .job_dividend (f_dividend),
    .job_len      (f_len),
    .job_mag      (f_mag),
    .job_neg      (f_neg),
    .job_wide     (f_wide),
    .job_done     (f_done)
  );

  assign q_wdata = {f_dividend, f_len, f_mag, f_neg, f_wide, f_done};

  // job queue decoupling front and back
  sfe_queue #(
    .WIDTH (JOB_W),
    .DEPTH (sfe_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {b_dividend, b_len, b_mag, b_neg, b_wide, b_done} = q_rdata;

  // back: serial divider, gain multiply, result register
  sfe_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .job_dividend (b_dividend),
    .job_len      (b_len),
    .job_mag      (b_mag),
    .job_neg      (b_neg),
    .job_wide     (b_wide),
    .job_done     (b_done),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_sample   (b_sample),
    .out_done     (out_region_done)
  );

  assign out_sample_out = b_sample;

`ifndef SYNTHESIS
  // front never writes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("job pushed into full queue");

  // back only takes a job that is there
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("job popped from empty queue");

  // a job taken by the back end leaves the queue with one fewer entry
  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_full) |=> !q_full) else $error("queue still full after pop");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty) else $error("result pending after reset");
`endif

endmodule
